@@ rtl/gcm_pkg.sv @@
`timescale 1ns / 1ps

package gcm_pkg;

    localparam int ACTION_W = 2;
    localparam int KIND_W   = 8;
    localparam int COUNT_W  = 3;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;
    localparam int IN_SLOTS = 4;

    // item actions; the unused code is handled by default arms
    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_MATCH = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCHED  = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_ACCEPTED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // per-lane control from the sequencing logic
    typedef struct packed {
        logic clr;
        logic wr;
        logic mark;
    } t_lane_ctl;

endpackage

@@ rtl/greedy_constraint_matcher.sv @@
`timescale 1ns / 1ps
// Channel   Valid      Stall      Payload
// input     i_valid    o_stall    i_action, i_entry_id, i_kind, i_participant_count,
//                                 i_participant_a .. i_participant_d
// output    o_valid    i_stall    o_status, o_proposition_id, o_construction_id,
//                                 o_matched_total
//
// All table lanes compare at once for each item and the lowest-index hit is picked in
// the same cycle; the result lands in the output register.
// Items are accepted every cycle while the output register is empty or being taken.
// Reset (synchronous, active low) empties the table, clears used marks, counts and
// the failure flag. A stalled output holds its item and stalls the input side.

module greedy_constraint_matcher #(
    parameter int TABLE_DEPTH      = 16,
    parameter int MAX_PARTICIPANTS = 4,
    parameter int ID_WIDTH         = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [gcm_pkg::ACTION_W-1:0]        i_action,
    input  logic [ID_WIDTH-1:0]                 i_entry_id,
    input  logic [gcm_pkg::KIND_W-1:0]          i_kind,
    input  logic [gcm_pkg::COUNT_W-1:0]         i_participant_count,
    input  logic [ID_WIDTH-1:0]                 i_participant_a,
    input  logic [ID_WIDTH-1:0]                 i_participant_b,
    input  logic [ID_WIDTH-1:0]                 i_participant_c,
    input  logic [ID_WIDTH-1:0]                 i_participant_d,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [gcm_pkg::STATUS_W-1:0]        o_status,
    output logic [ID_WIDTH-1:0]                 o_proposition_id,
    output logic [ID_WIDTH-1:0]                 o_construction_id,
    output logic [gcm_pkg::TOTAL_W-1:0]         o_matched_total
);
    import gcm_pkg::*;

    localparam int LD_W = $clog2(TABLE_DEPTH + 1);

    logic [IN_SLOTS-1:0][ID_WIDTH-1:0]         in_part;
    logic [MAX_PARTICIPANTS-1:0][ID_WIDTH-1:0] q_slots;
    t_lane_ctl                                 lane_ctl [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]                    hit;
    logic [TABLE_DEPTH-1:0][ID_WIDTH-1:0]      lane_ids;
    logic [TABLE_DEPTH-1:0]                    pick;
    logic                                      found;
    logic [ID_WIDTH-1:0]                       pick_id;
    logic                                      accept;
    logic                                      full;

    logic [LD_W-1:0]     r_loaded, n_loaded;
    logic [TOTAL_W-1:0]  r_pairs,  n_pairs;
    logic                r_failed, n_failed;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [ID_WIDTH-1:0] r_pid, n_pid;
    logic [ID_WIDTH-1:0] r_cid, n_cid;
    logic [TOTAL_W-1:0]  r_total;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_out_valid && i_stall;
    assign full    = r_loaded == LD_W'(TABLE_DEPTH);

    // mask participant slots at or beyond the count
    assign in_part = {i_participant_d, i_participant_c, i_participant_b, i_participant_a};
    for (genvar k = 0; k < MAX_PARTICIPANTS; k++) begin : g_slots
        if (k < IN_SLOTS) begin : g_in
            assign q_slots[k] = (4'(k) < {1'b0, i_participant_count}) ? in_part[k] : '0;
        end else begin : g_zero
            assign q_slots[k] = '0;
        end
    end

    // table lanes
    for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_lane
        gcm_lane #(
            .ID_WIDTH        (ID_WIDTH),
            .MAX_PARTICIPANTS(MAX_PARTICIPANTS),
            .LD_W            (LD_W),
            .LANE_IDX        (j)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[j]),
            .i_loaded(r_loaded),
            .i_id    (i_entry_id),
            .i_kind  (i_kind),
            .i_count (i_participant_count),
            .i_slots (q_slots),
            .o_hit   (hit[j]),
            .o_id    (lane_ids[j])
        );
    end

    gcm_merge #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_merge (
        .i_hit  (hit),
        .i_ids  (lane_ids),
        .o_found(found),
        .o_pick (pick),
        .o_id   (pick_id)
    );

    // drive lane writes, marks and clears
    always_comb begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            lane_ctl[j].clr  = accept && (t_action'(i_action) == ACT_START);
            lane_ctl[j].wr   = accept && (t_action'(i_action) == ACT_LOAD) && !full
                               && (r_loaded == LD_W'(j));
            lane_ctl[j].mark = accept && (t_action'(i_action) == ACT_MATCH) && !r_failed
                               && pick[j];
        end
    end

    // decide next session state and the result
    always_comb begin
        n_loaded = r_loaded;
        n_pairs  = r_pairs;
        n_failed = r_failed;
        n_status = ST_NO_MATCH;
        n_pid    = '0;
        n_cid    = '0;
        unique case (t_action'(i_action))
            ACT_START: begin
                n_loaded = '0;
                n_pairs  = '0;
                n_failed = 1'b0;
                n_status = ST_ACCEPTED;
            end
            ACT_LOAD: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_loaded = r_loaded + LD_W'(1);
                    n_status = ST_ACCEPTED;
                end
            end
            ACT_MATCH: begin
                priority if (r_failed) begin
                    n_status = ST_NO_MATCH;
                end else if (found) begin
                    n_pairs  = r_pairs + TOTAL_W'(1);
                    n_status = ST_MATCHED;
                    n_pid    = i_entry_id;
                    n_cid    = pick_id;
                end else begin
                    n_failed = 1'b1;
                    n_status = ST_NO_MATCH;
                end
            end
            default: begin
                n_status = ST_NO_MATCH;
            end
        endcase
        n_out_valid = accept || (r_out_valid && i_stall);
    end

    // hold session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_pairs     <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_loaded <= n_loaded;
                r_pairs  <= n_pairs;
                r_failed <= n_failed;
            end
        end
    end

    // load the output register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_pid    <= n_pid;
            r_cid    <= n_cid;
            r_total  <= n_pairs;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_proposition_id  = r_pid;
    assign o_construction_id = r_cid;
    assign o_matched_total   = r_total;

`ifndef SYNTHESIS
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= LD_W'(TABLE_DEPTH))
        else $error("table fill exceeds depth");

    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(pick) && (found == (pick != '0)))
        else $error("merge picked more than one lane");

    a_match_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (t_action'(i_action) == ACT_MATCH) && !r_failed && found
        |=> o_valid && (o_status == ST_MATCHED) && (r_pairs == $past(r_pairs) + TOTAL_W'(1)))
        else $error("match not reported");

    a_failed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_failed && (t_action'(i_action) == ACT_MATCH)
        |=> r_failed && (r_pairs == $past(r_pairs)) && (o_status == ST_NO_MATCH))
        else $error("failed session changed state");

    a_stall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");
`endif

endmodule

@@ rtl/gcm_lane.sv @@
`timescale 1ns / 1ps

module gcm_lane #(
    parameter int ID_WIDTH         = 16,
    parameter int MAX_PARTICIPANTS = 4,
    parameter int LD_W             = 5,
    parameter int LANE_IDX         = 0
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  gcm_pkg::t_lane_ctl                         i_ctl,
    input  logic [LD_W-1:0]                            i_loaded,
    input  logic [ID_WIDTH-1:0]                        i_id,
    input  logic [gcm_pkg::KIND_W-1:0]                 i_kind,
    input  logic [gcm_pkg::COUNT_W-1:0]                i_count,
    input  logic [MAX_PARTICIPANTS-1:0][ID_WIDTH-1:0]  i_slots,
    output logic                                       o_hit,
    output logic [ID_WIDTH-1:0]                        o_id
);
    import gcm_pkg::*;

    logic [ID_WIDTH-1:0]                       r_id;
    logic [KIND_W-1:0]                         r_kind;
    logic [COUNT_W-1:0]                        r_count;
    logic [MAX_PARTICIPANTS-1:0][ID_WIDTH-1:0] r_part;
    logic                                      r_used;
    logic [MAX_PARTICIPANTS-1:0]               slot_ok;
    logic                                      live;

    // store the entry on its load
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_id    <= i_id;
            r_kind  <= i_kind;
            r_count <= i_count;
            r_part  <= i_slots;
        end
    end

    // track the used mark; start and load clear it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_ctl.clr || i_ctl.wr) begin
            r_used <= 1'b0;
        end else if (i_ctl.mark) begin
            r_used <= 1'b1;
        end
    end

    // compare participants over the first count slots
    for (genvar k = 0; k < MAX_PARTICIPANTS; k++) begin : g_slot
        assign slot_ok[k] = (4'(k) >= {1'b0, i_count}) || (r_part[k] == i_slots[k]);
    end

    assign live  = LD_W'(LANE_IDX) < i_loaded;
    assign o_hit = live && !r_used && (r_kind == i_kind) && (r_count == i_count)
                   && (&slot_ok);
    assign o_id  = r_id;

endmodule

@@ rtl/gcm_merge.sv @@
`timescale 1ns / 1ps

module gcm_merge #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic [TABLE_DEPTH-1:0]               i_hit,
    input  logic [TABLE_DEPTH-1:0][ID_WIDTH-1:0] i_ids,
    output logic                                 o_found,
    output logic [TABLE_DEPTH-1:0]               o_pick,
    output logic [ID_WIDTH-1:0]                  o_id
);
    import gcm_pkg::*;

    // isolate the lowest-index hit
    assign o_pick  = i_hit & (~i_hit + TABLE_DEPTH'(1));
    assign o_found = |i_hit;

    // select the winning lane's id
    always_comb begin
        o_id = '0;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (o_pick[j]) begin
                o_id = o_id | i_ids[j];
            end
        end
    end

endmodule

@@ tb/sv/greedy_constraint_matcher_tb.sv @@
`timescale 1ns / 1ps

module greedy_constraint_matcher_tb;
    import gcm_pkg::*;

    localparam int TABLE_DEPTH     = 16;
    localparam int MAX_PARTS       = 4;
    localparam int ID_W            = 16;
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int ITEM_TARGET     = 1850;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    // the one action code the block leaves undefined
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]              action;
        logic [ID_W-1:0]                  id;
        logic [KIND_W-1:0]                kind;
        logic [COUNT_W-1:0]               count;
        logic [IN_SLOTS-1:0][ID_W-1:0]    part;
    } t_entry;

    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     prop_id;
        logic [ID_W-1:0]     cons_id;
        logic [TOTAL_W-1:0]  total;
    } t_reply;

    // Track the matching session and check every reply against it
    class pairing_ledger;
        logic [ID_W-1:0]                ids    [TABLE_DEPTH];
        logic [KIND_W-1:0]              kinds  [TABLE_DEPTH];
        logic [COUNT_W-1:0]             counts [TABLE_DEPTH];
        logic [IN_SLOTS-1:0][ID_W-1:0]  parts  [TABLE_DEPTH];
        bit                             used   [TABLE_DEPTH];
        int unsigned                    loaded;
        int unsigned                    pairs;
        bit                             failed;
        t_reply                         pending_replies [$];
        int unsigned                    mismatches;
        int unsigned                    checked;
        int unsigned                    bound;
        int unsigned                    misses;
        int unsigned                    full_drops;

        function void note_item(t_entry e);
            logic [IN_SLOTS-1:0][ID_W-1:0] slots;
            t_reply r;
            int hit;
            int k;
            // ids at or beyond the count are zeroed on both sides
            for (k = 0; k < IN_SLOTS; k++)
                slots[k] = (k < e.count) ? e.part[k] : '0;
            r.status  = ST_NO_MATCH;
            r.prop_id = '0;
            r.cons_id = '0;
            hit = -1;
            case (e.action)
                ACT_START: begin
                    loaded = 0;
                    pairs  = 0;
                    failed = 1'b0;
                    foreach (used[j]) used[j] = 1'b0;
                    r.status = ST_ACCEPTED;
                end
                ACT_LOAD: begin
                    if (loaded >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        ids[loaded]    = e.id;
                        kinds[loaded]  = e.kind;
                        counts[loaded] = e.count;
                        parts[loaded]  = slots;
                        used[loaded]   = 1'b0;
                        loaded++;
                        r.status = ST_ACCEPTED;
                    end
                end
                ACT_MATCH: begin
                    if (!failed) begin
                        // first free entry wins; counts above four still compare in full
                        for (k = 0; k < loaded && hit < 0; k++)
                            if (!used[k] && kinds[k] == e.kind && counts[k] == e.count
                                    && parts[k] == slots)
                                hit = k;
                        if (hit < 0) begin
                            failed = 1'b1;
                        end else begin
                            used[hit] = 1'b1;
                            pairs++;
                            r.status  = ST_MATCHED;
                            r.prop_id = e.id;
                            r.cons_id = ids[hit];
                        end
                    end
                end
                default: ;
            endcase
            r.total = TOTAL_W'(pairs);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status, logic [ID_W-1:0] prop_id,
                                  logic [ID_W-1:0] cons_id, logic [TOTAL_W-1:0] total);
            t_reply w;
            if (pending_replies.size() == 0) begin
                $error("reply with no item outstanding: status %0d", status);
                mismatches++;
                return;
            end
            w = pending_replies.pop_front();
            checked++;
            if (status !== w.status) begin
                $error("status: expected %0d, got %0d", w.status, status);
                mismatches++;
            end
            if (prop_id !== w.prop_id) begin
                $error("proposition_id: expected %0h, got %0h", w.prop_id, prop_id);
                mismatches++;
            end
            if (cons_id !== w.cons_id) begin
                $error("construction_id: expected %0h, got %0h", w.cons_id, cons_id);
                mismatches++;
            end
            if (total !== w.total) begin
                $error("matched_total: expected %0d, got %0d", w.total, total);
                mismatches++;
            end
            case (w.status)
                ST_MATCHED:  bound++;
                ST_NO_MATCH: misses++;
                ST_FULL:     full_drops++;
                default: ;
            endcase
        endfunction
    endclass

    logic                 i_clk               = 1'b0;
    logic                 i_rst_n             = 1'b0;
    logic                 i_valid             = 1'b0;
    logic                 i_stall             = 1'b0;
    logic [ACTION_W-1:0]  i_action            = '0;
    logic [ID_W-1:0]      i_entry_id          = '0;
    logic [KIND_W-1:0]    i_kind              = '0;
    logic [COUNT_W-1:0]   i_participant_count = '0;
    logic [ID_W-1:0]      i_participant_a     = '0;
    logic [ID_W-1:0]      i_participant_b     = '0;
    logic [ID_W-1:0]      i_participant_c     = '0;
    logic [ID_W-1:0]      i_participant_d     = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [ID_W-1:0]      o_proposition_id;
    logic [ID_W-1:0]      o_construction_id;
    logic [TOTAL_W-1:0]   o_matched_total;

    pairing_ledger ledger = new();

    int  tx_idle_pct   = 0;
    int  rx_stall_pct  = 0;
    bit  hold_off_req  = 1'b0;
    bit  hold_off_done = 1'b0;
    int  hold_left     = 0;
    int  items_sent    = 0;
    int  sessions      = 0;
    int  idle_cycles   = 0;

    greedy_constraint_matcher #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .MAX_PARTICIPANTS (MAX_PARTS),
        .ID_WIDTH         (ID_W)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_action            (i_action),
        .i_entry_id          (i_entry_id),
        .i_kind              (i_kind),
        .i_participant_count (i_participant_count),
        .i_participant_a     (i_participant_a),
        .i_participant_b     (i_participant_b),
        .i_participant_c     (i_participant_c),
        .i_participant_d     (i_participant_d),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_proposition_id    (o_proposition_id),
        .o_construction_id   (o_construction_id),
        .o_matched_total     (o_matched_total)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Note accepted items and check accepted replies, both at the edge
    always @(posedge i_clk) begin : monitor
        t_entry seen;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                seen.action = i_action;
                seen.id     = i_entry_id;
                seen.kind   = i_kind;
                seen.count  = i_participant_count;
                seen.part   = {i_participant_d, i_participant_c,
                               i_participant_b, i_participant_a};
                ledger.note_item(seen);
            end
            if (o_valid && !i_stall)
                ledger.check_reply(o_status, o_proposition_id, o_construction_id,
                                   o_matched_total);
        end
    end

    // Stall replies at random; once, hold off long enough to back up the input
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_off_req && !hold_off_done) begin
            i_stall       <= 1'b1;
            hold_left     <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("greedy_constraint_matcher_tb failed");
            $finish;
        end
    end

    function automatic t_entry make_item(logic [ACTION_W-1:0] action, logic [ID_W-1:0] id,
                                         logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] count,
                                         logic [ID_W-1:0] pa, logic [ID_W-1:0] pb,
                                         logic [ID_W-1:0] pc, logic [ID_W-1:0] pd);
        t_entry e;
        e.action = action;
        e.id     = id;
        e.kind   = kind;
        e.count  = count;
        e.part   = {pd, pc, pb, pa};
        return e;
    endfunction

    // Narrow items draw kinds and participant ids from a tiny pool so that duplicates are common
    function automatic t_entry random_entry(bit narrow);
        t_entry e;
        int k;
        e.action = ACT_LOAD;
        e.id     = ID_W'($urandom);
        e.kind   = narrow ? KIND_W'($urandom_range(0, 3)) : KIND_W'($urandom);
        e.count  = ($urandom_range(99) < 80) ? COUNT_W'($urandom_range(0, MAX_PARTS))
                                             : COUNT_W'($urandom_range(MAX_PARTS + 1, 7));
        for (k = 0; k < IN_SLOTS; k++)
            e.part[k] = narrow ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
        return e;
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(t_entry e);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_action            <= e.action;
        i_entry_id          <= e.id;
        i_kind              <= e.kind;
        i_participant_count <= e.count;
        i_participant_a     <= e.part[0];
        i_participant_b     <= e.part[1];
        i_participant_c     <= e.part[2];
        i_participant_d     <= e.part[3];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (e.action != ACT_UNUSED) items_sent++;
    endtask

    task automatic maybe_noise();
        t_entry e;
        if ($urandom_range(99) < 3) begin
            e = random_entry(1'b0);
            e.action = ACT_UNUSED;
            send_item(e);
        end
    endtask

    task automatic run_directed();
        // queries on an empty table fail the session, which then stays failed
        send_item(make_item(ACT_MATCH, 16'h0001, 8'h01, 3'd1, 16'h0001, '0, '0, '0));
        send_item(make_item(ACT_MATCH, 16'h0002, 8'h00, 3'd0, '0, '0, '0, '0));
        send_item(make_item(ACT_UNUSED, '1, '1, '1, '1, '1, '1, '1));
        send_item(make_item(ACT_START, '1, '1, '1, '1, '1, '1, '1));
        send_item(make_item(ACT_LOAD, 16'hFFFF, 8'hFF, 3'd4, '1, '1, '1, '1));
        send_item(make_item(ACT_LOAD, 16'h0000, 8'h00, 3'd0,
                            16'h1357, 16'h2468, 16'h9BDF, 16'hACE0));
        send_item(make_item(ACT_LOAD, 16'h1234, 8'h80, 3'd7,
                            16'h8000, 16'h4000, 16'h2000, 16'h1000));
        send_item(make_item(ACT_LOAD, 16'h8001, 8'hFF, 3'd4, '1, '1, '1, '1));
        send_item(make_item(ACT_LOAD, 16'h00AA, 8'h55, 3'd2,
                            16'h00F0, 16'h0F00, 16'hDEAD, 16'hBEEF));
        // duplicates bind in load order
        send_item(make_item(ACT_MATCH, 16'h0A0A, 8'hFF, 3'd4, '1, '1, '1, '1));
        send_item(make_item(ACT_MATCH, 16'h0B0B, 8'hFF, 3'd4, '1, '1, '1, '1));
        // ids past the count are ignored
        send_item(make_item(ACT_MATCH, 16'h0C0C, 8'h55, 3'd2,
                            16'h00F0, 16'h0F00, 16'h1111, 16'h2222));
        send_item(make_item(ACT_MATCH, 16'h0D0D, 8'h00, 3'd0,
                            16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF));
        send_item(make_item(ACT_MATCH, 16'hFFFF, 8'h80, 3'd7,
                            16'h8000, 16'h4000, 16'h2000, 16'h1000));
        // both duplicates used up: miss, then every query is refused
        send_item(make_item(ACT_MATCH, 16'h0E0E, 8'hFF, 3'd4, '1, '1, '1, '1));
        send_item(make_item(ACT_UNUSED, 16'h5555, 8'hAA, 3'd5, '0, '0, '0, '0));
        send_item(make_item(ACT_MATCH, 16'h0F0F, 8'h80, 3'd7,
                            16'h8000, 16'h4000, 16'h2000, 16'h1000));
        // counts above four differ even when the stored ids agree
        send_item(make_item(ACT_START, '0, '0, '0, '0, '0, '0, '0));
        send_item(make_item(ACT_LOAD, 16'h4321, 8'h80, 3'd6,
                            16'h8000, 16'h4000, 16'h2000, 16'h1000));
        send_item(make_item(ACT_MATCH, 16'h7777, 8'h80, 3'd7,
                            16'h8000, 16'h4000, 16'h2000, 16'h1000));
    endtask

    // One session: usually a start, a burst of loads, then queries mostly built from the loads
    task automatic run_session(bit overfill);
        t_entry stored [$];
        t_entry e;
        int     order [$];
        int     n_load;
        int     n_query;
        int     k;
        int     j;
        int     tmp;
        int     pick;
        int     roll;
        int     flip_slot;
        int     flip_bit;
        bit     narrow;
        narrow = 1'($urandom_range(1));
        if (overfill || $urandom_range(99) >= 8) begin
            e = random_entry(1'b0);
            e.action = ACT_START;
            send_item(e);
        end
        if (overfill || $urandom_range(99) < 10)
            n_load = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 3);
        else if ($urandom_range(99) < 25)
            n_load = $urandom_range(9, TABLE_DEPTH);
        else
            n_load = $urandom_range(1, 8);
        for (k = 0; k < n_load; k++) begin
            e = random_entry(narrow);
            send_item(e);
            if (stored.size() < TABLE_DEPTH) stored.push_back(e);
            maybe_noise();
        end
        // shuffle the query order
        for (k = 0; k < stored.size(); k++) order.push_back(k);
        for (k = order.size() - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        n_query = stored.size() + $urandom_range(0, 2);
        for (k = 0; k < n_query; k++) begin
            if (k < order.size() && $urandom_range(99) >= 10)
                pick = order[k];
            else
                pick = $urandom_range(stored.size() - 1);
            e = stored[pick];
            e.id = ID_W'($urandom);
            for (j = e.count; j < IN_SLOTS; j++) e.part[j] = ID_W'($urandom);
            roll = $urandom_range(99);
            if (roll < 6) begin
                e = random_entry(narrow);
            end else if (roll < 12) begin
                case ($urandom_range(2))
                    0: e.kind[$urandom_range(KIND_W - 1)] ^= 1'b1;
                    1: e.count = e.count + 1'b1;
                    default: begin
                        flip_slot = $urandom_range(IN_SLOTS - 1);
                        flip_bit  = $urandom_range(ID_W - 1);
                        e.part[flip_slot][flip_bit] ^= 1'b1;
                    end
                endcase
            end
            e.action = ACT_MATCH;
            send_item(e);
            maybe_noise();
        end
    endtask

    initial begin : stimulus
        int phase;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();

        // cycle through idling phases; the first session fills the table and may overfill it
        while (items_sent < ITEM_TARGET) begin
            phase = (items_sent / 150) % 4;
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 66; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 66; end
                default: begin tx_idle_pct = 8; rx_stall_pct <= 8; end
            endcase
            if (phase == 0 && items_sent >= 600 && !hold_off_done)
                hold_off_req <= 1'b1;
            run_session(sessions == 0);
            sessions++;
        end
        i_valid <= 1'b0;

        // let the last item be noted, drain outstanding replies, then allow for stragglers
        @(posedge i_clk);
        while (ledger.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items over %0d sessions with idle and stall phases",
                 items_sent, sessions);
        $display("and one long hold-off; checked %0d replies: %0d bound, %0d misses, %0d full.",
                 ledger.checked, ledger.bound, ledger.misses, ledger.full_drops);
        if (ledger.mismatches == 0)
            $display("greedy_constraint_matcher_tb passed");
        else
            $display("greedy_constraint_matcher_tb failed");
        $finish;
    end

endmodule
